[hdl/sbq_pkg.sv]
package sbq_pkg;

  // Number of audio channels carried by one frame (left, right).
  localparam int CHANNELS = 2;
  localparam int LEFT = 0;
  localparam int RIGHT = 1;

  // Default arithmetic sizes.
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF = 32;
  localparam int COEF_FRAC_BITS_DEF = 29;

  // Coefficient register file.
  localparam int NUM_COEFS = 5;
  localparam int COEF_IDX_W = $clog2(NUM_COEFS);

  typedef enum logic [COEF_IDX_W-1:0] {
    IDX_B0 = 3'd0,
    IDX_B1 = 3'd1,
    IDX_B2 = 3'd2,
    IDX_A1 = 3'd3,
    IDX_A2 = 3'd4
  } coef_idx_t;

  // Handshake controls that the top level hands to every lane.
  typedef struct packed {
    logic accept;   // a new frame enters the product stage
    logic advance;  // the product stage moves to the output register
    logic s1_full;  // the product stage holds a frame right now
  } lane_ctl_t;

  // Bus data is 32 bits unless a coefficient needs more.
  function automatic int apb_data_w(input int coef_w);
    return (coef_w > 32) ? 64 : 32;
  endfunction

  // Byte address bits below the register index.
  function automatic int apb_stride_bits(input int coef_w);
    return (coef_w > 32) ? 3 : 2;
  endfunction

  function automatic int apb_addr_w(input int coef_w);
    return COEF_IDX_W + apb_stride_bits(coef_w);
  endfunction

endpackage

[hdl/stereo_biquad_direct_form_one_unit.sv]
// Stereo direct form I biquad. Each request carries one left and one right
// sample; both channels run y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 with the
// same five signed coefficients (COEF_FRAC_BITS fractional bits, Q2.29 by
// default), the exact sum rounded half up and saturated to SAMPLE_WIDTH bits.
// clipped is set when either channel saturated in that frame, and the clamped
// value is what the recursion feeds back. The block accepts one frame every
// clock unless both stages are full and the result is held. Each channel has
// its own lane: a product stage registers the four terms that do not depend
// on the previous output, and a feedback stage multiplies a1 by the previous
// output, then sums and saturates combinationally, which is the loop that
// sets the one-frame-per-clock rate. The lanes' results merge into one output
// register, so a finished result can wait for the consumer while the next
// frame sits in the product stage. Coefficients are written over the APB port
// at byte address 4*i (8*i when a coefficient is wider than 32 bits) in the
// order b0, b1, b2, a1, a2, and should be changed only while no frame is in
// flight. Reset clears the sample history and loads b0 = 1.0, others 0.
module stereo_biquad_direct_form_one_unit #(
  parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH = sbq_pkg::COEF_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // Coefficient port.
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [sbq_pkg::apb_addr_w(COEF_WIDTH)-1:0] paddr,
  input  logic [sbq_pkg::apb_data_w(COEF_WIDTH)-1:0] pwdata,
  output logic [sbq_pkg::apb_data_w(COEF_WIDTH)-1:0] prdata,
  output logic pready,
  // Frame requests.
  input  logic                           frame_valid,
  output logic                           frame_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] left_in,
  input  logic signed [SAMPLE_WIDTH-1:0] right_in,
  // Result requests.
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic signed [SAMPLE_WIDTH-1:0] left_out,
  output logic signed [SAMPLE_WIDTH-1:0] right_out,
  output logic                           clipped
);

  localparam logic [SAMPLE_WIDTH-1:0] SampleMax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SampleMin = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [COEF_WIDTH-1:0]   coef [sbq_pkg::NUM_COEFS];
  logic signed [SAMPLE_WIDTH-1:0] lane_x [sbq_pkg::CHANNELS];
  logic signed [SAMPLE_WIDTH-1:0] lane_y [sbq_pkg::CHANNELS];
  logic [sbq_pkg::CHANNELS-1:0]   lane_sat;

  sbq_pkg::lane_ctl_t ctl;
  logic s1_valid, s1_valid_next;
  logic result_valid_next;

  // The configuration port never stalls.
  assign pready = 1'b1;

  sbq_regs #(
    .COEF_WIDTH     (COEF_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .coef    (coef)
  );

  // Pipeline control. The product stage moves on whenever the output register
  // is empty or being emptied; a new frame enters whenever the product stage
  // is empty or moving on in the same cycle.
  always_comb begin
    ctl.s1_full = s1_valid;
    ctl.advance = s1_valid && (!result_valid || result_ready);
    frame_ready = !s1_valid || ctl.advance;
    ctl.accept  = frame_valid && frame_ready;

    s1_valid_next = s1_valid;
    if (ctl.accept) begin
      s1_valid_next = 1'b1;
    end else if (ctl.advance) begin
      s1_valid_next = 1'b0;
    end

    result_valid_next = result_valid;
    if (ctl.advance) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= s1_valid_next;
      result_valid <= result_valid_next;
    end
  end

  assign lane_x[sbq_pkg::LEFT]  = left_in;
  assign lane_x[sbq_pkg::RIGHT] = right_in;

  // One filter lane per channel, all sharing the coefficient set.
  for (genvar ch = 0; ch < sbq_pkg::CHANNELS; ch++) begin : g_lane
    sbq_lane #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_WIDTH     (COEF_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .x    (lane_x[ch]),
      .coef (coef),
      .y    (lane_y[ch]),
      .sat  (lane_sat[ch])
    );
  end

  // Merge stage: collect the lanes' samples and combine their clip flags.
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      left_out  <= lane_y[sbq_pkg::LEFT];
      right_out <= lane_y[sbq_pkg::RIGHT];
      clipped   <= |lane_sat;
    end
  end

`ifndef SYNTHESIS
  // The input side only stalls when both stages hold a frame.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !frame_ready |-> (s1_valid && result_valid))
    else $error("frame request stalled with a free stage");

  // A result only appears after a frame left the product stage.
  a_result_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid))
    else $error("result without a frame in the product stage");

  // A frame entering an empty pipeline fills the product stage and then reaches the output register.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (ctl.accept && !s1_valid && (!result_valid || result_ready))
      |=> s1_valid ##1 result_valid)
    else $error("frame did not reach the output in two cycles");

  // A clipped frame carries at least one sample at full scale.
  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    (result_valid && clipped) |->
      (left_out == SampleMax || left_out == SampleMin ||
       right_out == SampleMax || right_out == SampleMin))
    else $error("clip flag set with no saturated sample");
`endif

endmodule

[hdl/sbq_regs.sv]
module sbq_regs #(
  parameter int COEF_WIDTH = sbq_pkg::COEF_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [sbq_pkg::apb_addr_w(COEF_WIDTH)-1:0] paddr,
  input  logic [sbq_pkg::apb_data_w(COEF_WIDTH)-1:0] pwdata,
  output logic [sbq_pkg::apb_data_w(COEF_WIDTH)-1:0] prdata,
  output logic signed [COEF_WIDTH-1:0] coef [sbq_pkg::NUM_COEFS]
);

  localparam int DataW = sbq_pkg::apb_data_w(COEF_WIDTH);
  localparam int AddrW = sbq_pkg::apb_addr_w(COEF_WIDTH);
  localparam int StrideBits = sbq_pkg::apb_stride_bits(COEF_WIDTH);
  localparam int IdxW = sbq_pkg::COEF_IDX_W;

  logic [IdxW-1:0] idx;
  logic            wr_en;
  logic            idx_ok;

  assign idx    = paddr[AddrW-1:StrideBits];
  assign idx_ok = (idx < IdxW'(sbq_pkg::NUM_COEFS));
  assign wr_en  = psel && penable && pwrite && idx_ok;

  // The feedforward gain on the current sample resets to unity, the rest to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sbq_pkg::NUM_COEFS; i++) begin
        coef[i] <= '0;
      end
      coef[sbq_pkg::IDX_B0] <= COEF_WIDTH'(1) << COEF_FRAC_BITS;
    end else if (wr_en) begin
      coef[idx] <= pwdata[COEF_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = DataW'(coef[idx]);
    end
  end

endmodule

[hdl/sbq_lane.sv]
module sbq_lane #(
  parameter int SAMPLE_WIDTH = sbq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH = sbq_pkg::COEF_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sbq_pkg::lane_ctl_t             ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic signed [COEF_WIDTH-1:0]   coef [sbq_pkg::NUM_COEFS],
  output logic signed [SAMPLE_WIDTH-1:0] y,
  output logic                           sat
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int SumW = PW + 3;
  localparam int AccW = (SumW > COEF_FRAC_BITS + SW + 1) ? SumW : COEF_FRAC_BITS + SW + 1;
  localparam int QW = AccW - COEF_FRAC_BITS;

  // Sample history, committed in frame order.
  logic signed [SW-1:0] x1, x2, y1, y2;

  // Product stage: every term except the one on the previous output.
  logic signed [PW-1:0] p_b0, p_b1, p_b2, p_a2;
  logic signed [SW-1:0] y2_op;

  logic signed [PW-1:0]   p_a1;
  logic signed [AccW-1:0] acc;
  logic signed [QW-1:0]   q;
  logic [QW-SW:0]         q_hi;
  logic                   ovf_pos, ovf_neg;

  // When the product stage is still busy, its frame has not yet committed,
  // so the newest committed output is the one two frames back.
  assign y2_op = ctl.s1_full ? y1 : y2;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      p_b0 <= coef[sbq_pkg::IDX_B0] * x;
      p_b1 <= coef[sbq_pkg::IDX_B1] * x1;
      p_b2 <= coef[sbq_pkg::IDX_B2] * x2;
      p_a2 <= coef[sbq_pkg::IDX_A2] * y2_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else begin
      if (ctl.accept) begin
        x2 <= x1;
        x1 <= x;
      end
      if (ctl.advance) begin
        y2 <= y1;
        y1 <= y;
      end
    end
  end

  // Feedback stage: one multiply on the previous output, the exact sum,
  // round half up and saturate.
  assign p_a1 = coef[sbq_pkg::IDX_A1] * y1;

  always_comb begin
    acc = AccW'(p_b0) + AccW'(p_b1) + AccW'(p_b2) - AccW'(p_a1) - AccW'(p_a2)
        + (AccW'(1) <<< (COEF_FRAC_BITS - 1));
    q       = acc[AccW-1:COEF_FRAC_BITS];
    q_hi    = q[QW-1:SW-1];
    ovf_pos = !q[QW-1] && (|q_hi);
    ovf_neg = q[QW-1] && !(&q_hi);
    sat     = ovf_pos || ovf_neg;
    if (ovf_pos) begin
      y = {1'b0, {(SW-1){1'b1}}};
    end else if (ovf_neg) begin
      y = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y = q[SW-1:0];
    end
  end

endmodule
